// ===== hw/rtl/skl_pkg.sv =====
// shared types and constants for the sorted key list
// no dependencies
package skl_pkg;

	localparam int CAPACITY = 16;
	localparam int KEY_W    = 32;
	localparam int MODE_W   = 2;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	typedef enum logic [MODE_W-1:0] {
		MODE_INSERT = 2'd0,
		MODE_REMOVE = 2'd1,
		MODE_SEARCH = 2'd2
	} skl_mode_t;

	// operation broadcast to every cell
	typedef struct packed {
		logic                    ins;
		logic                    rem;
		logic signed [KEY_W-1:0] key;
	} skl_op_t;

	// compare flags reported by a cell, both qualified by occupancy
	typedef struct packed {
		logic lt;
		logic eq;
	} skl_flags_t;

endpackage

// ===== hw/rtl/skl_if.sv =====
// valid/ready channel interfaces for operations and results
// depends on skl_pkg
interface skl_in_if import skl_pkg::*; (
	input logic clk
);
	logic                    valid;
	logic                    ready;
	logic [MODE_W-1:0]       mode;
	logic signed [KEY_W-1:0] key;

	modport source (input clk, output valid, input ready, output mode, output key);
	modport sink   (input clk, input valid, output ready, input mode, input key);
endinterface

interface skl_out_if import skl_pkg::*; (
	input logic clk
);
	logic                    valid;
	logic                    ready;
	logic                    success;
	logic signed [KEY_W-1:0] found_value;
	logic [CNT_W-1:0]        entry_count;

	modport source (input clk, output valid, input ready, output success,
		output found_value, output entry_count);
	modport sink   (input clk, input valid, output ready, input success,
		input found_value, input entry_count);
endinterface

// ===== hw/rtl/skl_cell.sv =====
// one slot of the sorted chain: holds a key, compares it, shifts left or right
// depends on skl_pkg
module skl_cell import skl_pkg::*; (
	input  logic                    clk,
	input  skl_op_t                 op,
	input  logic                    occupied,
	input  logic                    left_lt,
	input  logic signed [KEY_W-1:0] left_entry,
	input  logic signed [KEY_W-1:0] right_entry,
	output skl_flags_t              flags,
	output logic signed [KEY_W-1:0] entry
);

	logic signed [KEY_W-1:0] entry_q;
	logic signed [KEY_W-1:0] entry_d;

	assign flags.lt = occupied && (entry_q < op.key);
	assign flags.eq = occupied && (entry_q == op.key);
	assign entry    = entry_q;

	always_comb begin
		entry_d = entry_q;
		if (op.ins && !flags.lt) begin
			// insertion point takes the key, everything above moves up
			entry_d = left_lt ? op.key : left_entry;
		end else if (op.rem && !flags.lt) begin
			entry_d = right_entry;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

endmodule

// ===== hw/rtl/sorted_key_list.sv =====
// top level of the sorted key list: cell chain, count and result register
// depends on skl_pkg, skl_if, skl_cell

// Ascending table of up to CAPACITY signed keys held in a chain of compare
// cells. Operations are insert, remove and search; while the output side
// keeps up, one operation is taken per clock cycle and its result appears
// in the output register on the next cycle. A new operation is taken while
// a result waits, as long as the output register is free or being emptied
// in the same cycle. The cycle time is set by the parallel compare in every
// cell, the OR over all the equal flags and the shift that follows. No
// clearing pass after reset: stale keys above the count are masked.
module sorted_key_list import skl_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	skl_in_if.sink  in,
	skl_out_if.source out
);

	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        count_d;
	logic                    out_valid_q;
	logic                    success_q;
	logic signed [KEY_W-1:0] found_value_q;
	logic [CNT_W-1:0]        entry_count_q;

	logic                    accept;
	logic                    found;
	logic                    success_d;
	skl_op_t                 op;
	skl_flags_t              flags [CAPACITY];
	logic signed [KEY_W-1:0] entries [CAPACITY];
	logic [CAPACITY-1:0]     eq_vec;

	// handshake: the output register parts both sides
	assign in.ready = !out_valid_q || out.ready;
	assign accept   = in.valid && in.ready;

	// broadcast operation, enables already include full/absent checks
	assign op.key = in.key;
	assign op.ins = accept && (in.mode == MODE_INSERT) &&
		(count_q < CNT_W'(CAPACITY));
	assign op.rem = accept && (in.mode == MODE_REMOVE) && found;

	// chain of cells, each sees its neighbours' keys
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                    left_lt;
		logic signed [KEY_W-1:0] left_entry;
		logic signed [KEY_W-1:0] right_entry;

		if (i == 0) begin : g_head
			// head cell behaves as if a smaller key lay before it
			assign left_lt    = 1'b1;
			assign left_entry = entries[0];
		end else begin : g_body
			assign left_lt    = flags[i-1].lt;
			assign left_entry = entries[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_entry = entries[i];
		end else begin : g_inner
			assign right_entry = entries[i+1];
		end

		assign eq_vec[i] = flags[i].eq;

		skl_cell u_cell (
			.clk         (clk),
			.op          (op),
			.occupied    (CNT_W'(i) < count_q),
			.left_lt     (left_lt),
			.left_entry  (left_entry),
			.right_entry (right_entry),
			.flags       (flags[i]),
			.entry       (entries[i])
		);
	end

	assign found = |eq_vec;

	always_comb begin
		count_d   = count_q;
		success_d = 1'b0;
		if (op.ins) begin
			count_d   = count_q + CNT_W'(1);
			success_d = 1'b1;
		end else if (op.rem) begin
			count_d   = count_q - CNT_W'(1);
			success_d = 1'b1;
		end else if (in.mode == MODE_SEARCH) begin
			success_d = found;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_d;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload, captured with each accepted transaction
	always_ff @(posedge clk) begin
		if (accept) begin
			success_q     <= success_d;
			found_value_q <= (in.mode == MODE_SEARCH && found) ? in.key : '0;
			entry_count_q <= count_d;
		end
	end

	assign out.valid       = out_valid_q;
	assign out.success     = success_q;
	assign out.found_value = found_value_q;
	assign out.entry_count = entry_count_q;

endmodule
